@@ sv/redf_pkg.sv @@
`timescale 1ns / 1ps
package redf_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int TASK_W    = 3;
  localparam int SETUP_W   = 34;
  localparam int PER_W     = 16;
  localparam int COST_W    = 16;
  localparam int LOAD_W    = 20;
  localparam int CNT_W     = 16;
  localparam int QLEN_W    = 4;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  // Outcome counter slots.
  localparam int CNT_SUCC_HIGH = 0;
  localparam int CNT_SUCC_LOW  = 1;
  localparam int CNT_FAIL_HIGH = 2;
  localparam int CNT_FAIL_LOW  = 3;
  localparam int NUM_CNT       = 4;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_READY  = 2'd1,
    PH_REJECT = 2'd2
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RET0,
    S_RET1,
    S_RET2,
    S_RM_LOOP,
    S_RM_A,
    S_RM_B,
    S_RI_LOOP,
    S_RI_A,
    S_INS_LOOP,
    S_INS_A,
    S_INS_B,
    S_INS_FIN,
    S_RA_RD,
    S_RA_CHK,
    S_RA_PICK,
    S_RA_ID,
    S_FL_RD,
    S_FL_CHK,
    S_FL_NEXT,
    S_RL_RD,
    S_RL_CHK,
    S_RL_NEXT,
    S_EV_LOOP,
    S_EV_A,
    S_EV_B,
    S_EV_W,
    S_RETURN,
    S_OUT,
    S_OUT_A,
    S_DONE
  } seq_state_t;

  // Where a queue insert or removal hands control back to.
  typedef enum logic [2:0] {
    RT_RETIRE,
    RT_READMIT,
    RT_READMIT_RM,
    RT_FAIL,
    RT_RELEASE,
    RT_EVICT
  } ret_t;

  typedef struct packed {
    logic                running_valid;
    logic [TASK_W-1:0]   running_task;
    logic [CNT_W-1:0]    succeeded_high;
    logic [CNT_W-1:0]    succeeded_low;
    logic [CNT_W-1:0]    failed_high;
    logic [CNT_W-1:0]    failed_low;
  } result_t;

  function automatic logic [PER_W-1:0] per_of(input logic [SETUP_W-1:0] s);
    per_of = s[PER_W-1:0];
  endfunction

  function automatic logic [COST_W-1:0] cost_of(input logic [SETUP_W-1:0] s);
    cost_of = s[PER_W+COST_W-1:PER_W];
  endfunction

  function automatic logic is_high(input logic [SETUP_W-1:0] s);
    is_high = s[PER_W+COST_W];
  endfunction

  function automatic logic is_present(input logic [SETUP_W-1:0] s);
    is_present = s[PER_W+COST_W+1];
  endfunction

  function automatic logic [LOAD_W-1:0] load_add(input logic [LOAD_W-1:0] a,
                                                 input logic [LOAD_W-1:0] b);
    logic [LOAD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    load_add = s[LOAD_W] ? {LOAD_W{1'b1}} : s[LOAD_W-1:0];
  endfunction

  function automatic logic [LOAD_W-1:0] load_sub(input logic [LOAD_W-1:0] a,
                                                 input logic [LOAD_W-1:0] b);
    load_sub = (a > b) ? (a - b) : '0;
  endfunction

  function automatic logic over(input logic [LOAD_W-1:0] load,
                                input logic [SETUP_W-1:0] s);
    over = load > LOAD_W'(per_of(s));
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

@@ sv/robust_edf_admission_scheduler_top.sv @@
`timescale 1ns / 1ps
// Tick-driven earliest-deadline admission scheduler for up to eight periodic
// tasks of low or high criticality.
// Each beat on the in_ stream is one scheduler tick; in_tdata[0] says the job
// at the queue head has finished. Each tick yields exactly one beat on the
// out_ stream with the running task and the four saturating outcome counters.
// Task periods, costs and flags are written over the cfg_ APB port, one
// 34-bit register per task at byte address 8*i; the user must write them
// only while no tick is open, which the block itself does not enforce. A
// tick is worked through by a sequencer that reads, modifies and writes back
// a task record memory and a queue order memory, one access each per cycle.
// The failure and release scans visit each task slot with a read, a check
// and a next state, the re-admission scan with a read and a check state;
// every insert, removal and eviction pass runs a loop, a read and an update
// state for each queue entry it touches. The next tick is taken in the cycle
// after the result is handed to the output register, once the sequencer is idle.
// The result sits in an output register, so a new tick can be accepted while
// the previous result still waits; if the receiver stalls longer, the
// sequencer holds its finished result until the register frees up.
// Synchronous reset clears the configuration, time, queue and counters; task
// records read as idle until first written.
module robust_edf_admission_scheduler_top import redf_pkg::*; #(
  parameter int MAX_TASKS = 8,
  parameter int TIME_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,     // [0] job_done
  output logic              out_tvalid,
  input  logic              out_tready,
  // [2:0] running_task, [18:3] succeeded_high, [34:19] succeeded_low,
  // [50:35] failed_high, [66:51] failed_low, [71:67] zero
  output logic [71:0]       out_tdata,
  output logic [0:0]        out_tuser,    // [0] running_valid
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [SETUP_W-1:0] setup_r [NUM_SLOTS];
  logic               cfg_wr;
  logic [TASK_W-1:0]  cfg_idx;

  logic    seq_idle, res_valid, res_take;
  result_t res;
  logic    out_tvalid_r;
  result_t out_res_r;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[ADDR_W-1:ADDR_W-TASK_W];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = DATA_W'(setup_r[cfg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < NUM_SLOTS; n++) begin
        setup_r[n] <= '0;
      end
    end else if (cfg_wr) begin
      setup_r[cfg_idx] <= cfg_pwdata[SETUP_W-1:0];
    end
  end

  redf_seq #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid && in_tready),
    .job_done  (in_tdata[0]),
    .setup     (setup_r),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  assign in_tready = seq_idle;

  // The output register takes a finished result when it is empty or its
  // beat is leaving in the same cycle.
  assign res_take = res_valid && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_take) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_res_r.running_valid;
  assign out_tdata  = {5'b0, out_res_r.failed_low, out_res_r.failed_high,
                       out_res_r.succeeded_low, out_res_r.succeeded_high,
                       out_res_r.running_task};

  // A tick is never accepted on two consecutive edges: the sequencer leaves
  // idle as soon as it takes one.
  a_one_tick_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("tick accepted while sequencer busy");

  // An empty queue reports task index zero.
  a_idle_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[2:0] == 3'd0))
    else $error("nonzero task with no running job");

  // A result handed over always shows up as a pending beat.
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_tvalid)
    else $error("result lost at output register");

endmodule

@@ sv/redf_seq.sv @@
`timescale 1ns / 1ps
module redf_seq import redf_pkg::*; #(
  parameter int MAX_TASKS = 8,
  parameter int TIME_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               job_done,
  input  logic [SETUP_W-1:0] setup [NUM_SLOTS],
  output logic               idle,
  output logic               res_valid,
  input  logic               res_take,
  output result_t            res
);

  localparam int TW1 = TIME_BITS + 1;

  typedef struct packed {
    phase_t                phase;
    logic [TIME_BITS-1:0]  wake;
    logic [TIME_BITS-1:0]  dl;
    logic [LOAD_W-1:0]     load;
  } trec_t;

  function automatic logic [TIME_BITS-1:0] time_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [PER_W-1:0] b);
    logic [TIME_BITS:0] s;
    s = TW1'(a) + TW1'(b);
    time_add = s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  // Task record memory with per-entry valid bits, and the queue order memory.
  trec_t             tmem [NUM_SLOTS];
  logic              tvalid_r [NUM_SLOTS];
  trec_t             t_rd_r;
  logic              t_rv_r;
  logic [TASK_W-1:0] qmem [NUM_SLOTS];
  logic [TASK_W-1:0] q_rd_r;

  logic              t_we, q_we;
  logic [TASK_W-1:0] t_ra, t_wa, q_ra, q_wa, q_wd;
  trec_t             t_wd;
  trec_t             rec;

  seq_state_t           state_r, state_nxt;
  ret_t                 ret_r, ret_nxt;
  logic [TIME_BITS-1:0] t_r, t_nxt;
  logic [QLEN_W-1:0]    qlen_r, qlen_nxt;
  logic [CNT_W-1:0]     cnt_r [NUM_CNT];
  logic [CNT_W-1:0]     cnt_nxt [NUM_CNT];
  logic                 jd_r, jd_nxt;
  logic [QLEN_W-1:0]    i_r, i_nxt, k_r, k_nxt, pos_r, pos_nxt, llk_r, llk_nxt;
  logic [TASK_W-1:0]    id_r, id_nxt, e_r, e_nxt, head_r, head_nxt;
  logic [TASK_W-1:0]    hid_r, hid_nxt, lid_r, lid_nxt, llid_r, llid_nxt;
  logic                 hf_r, hf_nxt, lf_r, lf_nxt, llf_r, llf_nxt, ok_r, ok_nxt;
  logic [TIME_BITS-1:0] hdl_r, hdl_nxt, ldl_r, ldl_nxt, wake_r, wake_nxt, dl_r, dl_nxt;
  logic [COST_W-1:0]    c_r, c_nxt;
  logic [LOAD_W-1:0]    prev_r, prev_nxt;

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_wa] <= t_wd;
    end
    if (q_we) begin
      qmem[q_wa] <= q_wd;
    end
    t_rd_r <= tmem[t_ra];
    q_rd_r <= qmem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < NUM_SLOTS; n++) begin
        tvalid_r[n] <= 1'b0;
      end
      t_rv_r <= 1'b0;
    end else begin
      if (t_we) begin
        tvalid_r[t_wa] <= 1'b1;
      end
      t_rv_r <= tvalid_r[t_ra];
    end
  end

  assign rec = t_rv_r ? t_rd_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= RT_RETIRE;
      t_r     <= '0;
      qlen_r  <= '0;
      for (int n = 0; n < NUM_CNT; n++) begin
        cnt_r[n] <= '0;
      end
      head_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      t_r     <= t_nxt;
      qlen_r  <= qlen_nxt;
      for (int n = 0; n < NUM_CNT; n++) begin
        cnt_r[n] <= cnt_nxt[n];
      end
      head_r  <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    jd_r   <= jd_nxt;
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    pos_r  <= pos_nxt;
    llk_r  <= llk_nxt;
    id_r   <= id_nxt;
    e_r    <= e_nxt;
    hid_r  <= hid_nxt;
    lid_r  <= lid_nxt;
    llid_r <= llid_nxt;
    hf_r   <= hf_nxt;
    lf_r   <= lf_nxt;
    llf_r  <= llf_nxt;
    ok_r   <= ok_nxt;
    hdl_r  <= hdl_nxt;
    ldl_r  <= ldl_nxt;
    wake_r <= wake_nxt;
    dl_r   <= dl_nxt;
    c_r    <= c_nxt;
    prev_r <= prev_nxt;
  end

  always_comb begin
    logic [LOAD_W-1:0] nl;
    logic              okf;
    trec_t             w;
    state_nxt = state_r;
    ret_nxt   = ret_r;
    t_nxt     = t_r;
    qlen_nxt  = qlen_r;
    for (int n = 0; n < NUM_CNT; n++) begin
      cnt_nxt[n] = cnt_r[n];
    end
    jd_nxt   = jd_r;
    i_nxt    = i_r;
    k_nxt    = k_r;
    pos_nxt  = pos_r;
    llk_nxt  = llk_r;
    id_nxt   = id_r;
    e_nxt    = e_r;
    head_nxt = head_r;
    hid_nxt  = hid_r;
    lid_nxt  = lid_r;
    llid_nxt = llid_r;
    hf_nxt   = hf_r;
    lf_nxt   = lf_r;
    llf_nxt  = llf_r;
    ok_nxt   = ok_r;
    hdl_nxt  = hdl_r;
    ldl_nxt  = ldl_r;
    wake_nxt = wake_r;
    dl_nxt   = dl_r;
    c_nxt    = c_r;
    prev_nxt = prev_r;
    t_we = 1'b0;
    t_wa = '0;
    t_wd = rec;
    t_ra = '0;
    q_we = 1'b0;
    q_wa = '0;
    q_wd = '0;
    q_ra = '0;
    nl   = '0;
    okf  = 1'b0;
    w    = rec;
    idle      = 1'b0;
    res_valid = 1'b0;

    case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          jd_nxt    = job_done;
          state_nxt = S_RET0;
        end
      end

      // Retirement of the head job.
      S_RET0: begin
        if (jd_r && qlen_r != '0) begin
          q_ra      = '0;
          state_nxt = S_RET1;
        end else begin
          i_nxt     = '0;
          state_nxt = S_FL_RD;
        end
      end
      S_RET1: begin
        id_nxt    = q_rd_r;
        t_ra      = q_rd_r;
        state_nxt = S_RET2;
      end
      S_RET2: begin
        if (is_high(setup[id_r])) begin
          cnt_nxt[CNT_SUCC_HIGH] = sat_inc(cnt_r[CNT_SUCC_HIGH]);
        end else begin
          cnt_nxt[CNT_SUCC_LOW] = sat_inc(cnt_r[CNT_SUCC_LOW]);
        end
        w.phase   = PH_IDLE;
        w.wake    = time_add(rec.wake, per_of(setup[id_r]));
        t_we      = 1'b1;
        t_wa      = id_r;
        t_wd      = w;
        k_nxt     = QLEN_W'(1);
        c_nxt     = cost_of(setup[id_r]);
        ok_nxt    = 1'b1;
        ret_nxt   = RT_RETIRE;
        state_nxt = S_RM_LOOP;
      end

      // Removal: shift later entries down and take the cost off their loads.
      S_RM_LOOP: begin
        if (k_r < qlen_r) begin
          q_ra      = k_r[TASK_W-1:0];
          state_nxt = S_RM_A;
        end else begin
          qlen_nxt  = qlen_r - QLEN_W'(1);
          state_nxt = S_RETURN;
        end
      end
      S_RM_A: begin
        e_nxt     = q_rd_r;
        t_ra      = q_rd_r;
        q_we      = 1'b1;
        q_wa      = TASK_W'(k_r - QLEN_W'(1));
        q_wd      = q_rd_r;
        state_nxt = S_RM_B;
      end
      S_RM_B: begin
        nl     = load_sub(rec.load, LOAD_W'(c_r));
        w.load = nl;
        t_we   = 1'b1;
        t_wa   = e_r;
        t_wd   = w;
        if (over(nl, setup[e_r])) begin
          ok_nxt = 1'b0;
        end
        k_nxt     = k_r + QLEN_W'(1);
        state_nxt = S_RM_LOOP;
      end

      // Removal by task: find its queue position first.
      S_RI_LOOP: begin
        if (k_r < qlen_r) begin
          q_ra      = k_r[TASK_W-1:0];
          state_nxt = S_RI_A;
        end else begin
          state_nxt = S_RETURN;
        end
      end
      S_RI_A: begin
        k_nxt = k_r + QLEN_W'(1);
        if (q_rd_r == id_r) begin
          c_nxt     = cost_of(setup[id_r]);
          ok_nxt    = 1'b1;
          state_nxt = S_RM_LOOP;
        end else begin
          state_nxt = S_RI_LOOP;
        end
      end

      // Insertion from the tail, shifting later-deadline entries up.
      S_INS_LOOP: begin
        if (pos_r != '0) begin
          q_ra      = TASK_W'(pos_r - QLEN_W'(1));
          state_nxt = S_INS_A;
        end else begin
          prev_nxt  = '0;
          state_nxt = S_INS_FIN;
        end
      end
      S_INS_A: begin
        e_nxt     = q_rd_r;
        t_ra      = q_rd_r;
        state_nxt = S_INS_B;
      end
      S_INS_B: begin
        if (dl_r < rec.dl) begin
          nl     = load_add(rec.load, LOAD_W'(c_r));
          w.load = nl;
          t_we   = 1'b1;
          t_wa   = e_r;
          t_wd   = w;
          if (over(nl, setup[e_r])) begin
            ok_nxt = 1'b0;
          end
          q_we      = 1'b1;
          q_wa      = pos_r[TASK_W-1:0];
          q_wd      = e_r;
          pos_nxt   = pos_r - QLEN_W'(1);
          state_nxt = S_INS_LOOP;
        end else begin
          prev_nxt  = rec.load;
          state_nxt = S_INS_FIN;
        end
      end
      S_INS_FIN: begin
        nl     = load_add(LOAD_W'(c_r), prev_r);
        okf    = ok_r && !over(nl, setup[id_r]);
        w.wake = wake_r;
        w.dl   = dl_r;
        w.load = nl;
        w.phase = (ret_r == RT_READMIT && !okf) ? PH_REJECT : PH_READY;
        t_we      = 1'b1;
        t_wa      = id_r;
        t_wd      = w;
        q_we      = 1'b1;
        q_wa      = pos_r[TASK_W-1:0];
        q_wd      = id_r;
        qlen_nxt  = qlen_r + QLEN_W'(1);
        ok_nxt    = okf;
        state_nxt = S_RETURN;
      end

      S_RETURN: begin
        case (ret_r)
          RT_RETIRE: begin
            i_nxt = '0;
            if (ok_r) begin
              hf_nxt    = 1'b0;
              lf_nxt    = 1'b0;
              state_nxt = S_RA_RD;
            end else begin
              state_nxt = S_FL_RD;
            end
          end
          RT_READMIT: begin
            if (ok_r) begin
              i_nxt     = '0;
              state_nxt = S_FL_RD;
            end else begin
              ret_nxt   = RT_READMIT_RM;
              k_nxt     = '0;
              state_nxt = S_RI_LOOP;
            end
          end
          RT_READMIT_RM: begin
            i_nxt     = '0;
            state_nxt = S_FL_RD;
          end
          RT_FAIL: begin
            state_nxt = S_FL_NEXT;
          end
          RT_RELEASE, RT_EVICT: begin
            k_nxt     = '0;
            llf_nxt   = 1'b0;
            state_nxt = S_EV_LOOP;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      // Re-admission: latest-deadline rejected task, high criticality first.
      S_RA_RD: begin
        t_ra      = i_r[TASK_W-1:0];
        state_nxt = S_RA_CHK;
      end
      S_RA_CHK: begin
        if (rec.phase == PH_REJECT) begin
          if (is_high(setup[i_r[TASK_W-1:0]])) begin
            if (!hf_r || rec.dl > hdl_r) begin
              hf_nxt  = 1'b1;
              hid_nxt = i_r[TASK_W-1:0];
              hdl_nxt = rec.dl;
            end
          end else begin
            if (!lf_r || rec.dl > ldl_r) begin
              lf_nxt  = 1'b1;
              lid_nxt = i_r[TASK_W-1:0];
              ldl_nxt = rec.dl;
            end
          end
        end
        i_nxt = i_r + QLEN_W'(1);
        if (i_r + QLEN_W'(1) < QLEN_W'(MAX_TASKS)) begin
          state_nxt = S_RA_RD;
        end else begin
          state_nxt = S_RA_PICK;
        end
      end
      S_RA_PICK: begin
        if (hf_r) begin
          id_nxt    = hid_r;
          t_ra      = hid_r;
          state_nxt = S_RA_ID;
        end else if (lf_r) begin
          id_nxt    = lid_r;
          t_ra      = lid_r;
          state_nxt = S_RA_ID;
        end else begin
          i_nxt     = '0;
          state_nxt = S_FL_RD;
        end
      end
      S_RA_ID: begin
        wake_nxt  = rec.wake;
        dl_nxt    = rec.dl;
        ret_nxt   = RT_READMIT;
        pos_nxt   = qlen_r;
        c_nxt     = cost_of(setup[id_r]);
        ok_nxt    = 1'b1;
        state_nxt = S_INS_LOOP;
      end

      // Deadline misses.
      S_FL_RD: begin
        t_ra      = i_r[TASK_W-1:0];
        state_nxt = S_FL_CHK;
      end
      S_FL_CHK: begin
        if ((rec.phase == PH_READY || rec.phase == PH_REJECT) && t_r > rec.dl) begin
          if (is_high(setup[i_r[TASK_W-1:0]])) begin
            cnt_nxt[CNT_FAIL_HIGH] = sat_inc(cnt_r[CNT_FAIL_HIGH]);
          end else begin
            cnt_nxt[CNT_FAIL_LOW] = sat_inc(cnt_r[CNT_FAIL_LOW]);
          end
          w.phase = PH_IDLE;
          w.wake  = time_add(rec.wake, per_of(setup[i_r[TASK_W-1:0]]));
          t_we    = 1'b1;
          t_wa    = i_r[TASK_W-1:0];
          t_wd    = w;
          if (rec.phase == PH_READY) begin
            id_nxt    = i_r[TASK_W-1:0];
            ret_nxt   = RT_FAIL;
            k_nxt     = '0;
            state_nxt = S_RI_LOOP;
          end else begin
            state_nxt = S_FL_NEXT;
          end
        end else begin
          state_nxt = S_FL_NEXT;
        end
      end
      S_FL_NEXT: begin
        if (i_r + QLEN_W'(1) < QLEN_W'(MAX_TASKS)) begin
          i_nxt     = i_r + QLEN_W'(1);
          state_nxt = S_FL_RD;
        end else begin
          i_nxt     = '0;
          state_nxt = S_RL_RD;
        end
      end

      // Release of due tasks.
      S_RL_RD: begin
        t_ra      = i_r[TASK_W-1:0];
        state_nxt = S_RL_CHK;
      end
      S_RL_CHK: begin
        if (is_present(setup[i_r[TASK_W-1:0]]) && rec.phase == PH_IDLE && t_r >= rec.wake)
        begin
          id_nxt    = i_r[TASK_W-1:0];
          wake_nxt  = rec.wake;
          dl_nxt    = time_add(rec.wake, per_of(setup[i_r[TASK_W-1:0]]));
          ret_nxt   = RT_RELEASE;
          pos_nxt   = qlen_r;
          c_nxt     = cost_of(setup[i_r[TASK_W-1:0]]);
          ok_nxt    = 1'b1;
          state_nxt = S_INS_LOOP;
        end else begin
          state_nxt = S_RL_NEXT;
        end
      end
      S_RL_NEXT: begin
        if (i_r + QLEN_W'(1) < QLEN_W'(MAX_TASKS)) begin
          i_nxt     = i_r + QLEN_W'(1);
          state_nxt = S_RL_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end

      // Eviction: stop at the first overload; reject it or the last low before.
      S_EV_LOOP: begin
        if (k_r < qlen_r) begin
          q_ra      = k_r[TASK_W-1:0];
          state_nxt = S_EV_A;
        end else begin
          state_nxt = S_RL_NEXT;
        end
      end
      S_EV_A: begin
        e_nxt     = q_rd_r;
        t_ra      = q_rd_r;
        state_nxt = S_EV_B;
      end
      S_EV_B: begin
        if (over(rec.load, setup[e_r])) begin
          if (!is_high(setup[e_r]) || !llf_r) begin
            w.phase   = PH_REJECT;
            t_we      = 1'b1;
            t_wa      = e_r;
            t_wd      = w;
            id_nxt    = e_r;
            c_nxt     = cost_of(setup[e_r]);
            k_nxt     = k_r + QLEN_W'(1);
            ok_nxt    = 1'b1;
            ret_nxt   = RT_EVICT;
            state_nxt = S_RM_LOOP;
          end else begin
            id_nxt    = llid_r;
            t_ra      = llid_r;
            state_nxt = S_EV_W;
          end
        end else begin
          if (!is_high(setup[e_r])) begin
            llf_nxt  = 1'b1;
            llk_nxt  = k_r;
            llid_nxt = e_r;
          end
          k_nxt     = k_r + QLEN_W'(1);
          state_nxt = S_EV_LOOP;
        end
      end
      S_EV_W: begin
        w.phase   = PH_REJECT;
        t_we      = 1'b1;
        t_wa      = id_r;
        t_wd      = w;
        c_nxt     = cost_of(setup[id_r]);
        k_nxt     = llk_r + QLEN_W'(1);
        ok_nxt    = 1'b1;
        ret_nxt   = RT_EVICT;
        state_nxt = S_RM_LOOP;
      end

      // End of tick: advance time and fetch the head for the result.
      S_OUT: begin
        if (t_r != {TIME_BITS{1'b1}}) begin
          t_nxt = t_r + TIME_BITS'(1);
        end
        if (qlen_r != '0) begin
          q_ra      = '0;
          state_nxt = S_OUT_A;
        end else begin
          head_nxt  = '0;
          state_nxt = S_DONE;
        end
      end
      S_OUT_A: begin
        head_nxt  = q_rd_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.running_valid  = (qlen_r != '0);
  assign res.running_task   = head_r;
  assign res.succeeded_high = cnt_r[CNT_SUCC_HIGH];
  assign res.succeeded_low  = cnt_r[CNT_SUCC_LOW];
  assign res.failed_high    = cnt_r[CNT_FAIL_HIGH];
  assign res.failed_low     = cnt_r[CNT_FAIL_LOW];

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench import redf_pkg::*;;

  localparam int NTASK      = 8;
  localparam int TICK_LIMIT = 10000000;
  localparam int DRAIN_WAIT = 300;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [71:0]       out_tdata;
  logic [0:0]        out_tuser;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  robust_edf_admission_scheduler_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Scheduler shadow state, kept in step with every accepted tick.
  logic [SETUP_W-1:0] task_setup [NTASK];
  phase_t             task_state [NTASK];
  logic [31:0]        wake_at    [NTASK];
  logic [31:0]        due_at     [NTASK];
  logic [LOAD_W-1:0]  run_load   [NTASK];
  logic [TASK_W-1:0]  edf_order  [NTASK];
  int                 edf_len;
  logic [31:0]        sched_now;
  logic [CNT_W-1:0]   outcome    [NUM_CNT];

  bit      tick_done_q [$];
  result_t sched_expect_q [$];
  int      fail_count;
  int      cycle_count;
  bit      steady;

  function automatic logic [LOAD_W-1:0] per_w(int i);
    return LOAD_W'(task_setup[i][15:0]);
  endfunction

  function automatic logic [LOAD_W-1:0] cost_w(int i);
    return LOAD_W'(task_setup[i][31:16]);
  endfunction

  function automatic logic [31:0] time_plus(logic [31:0] a, logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [LOAD_W-1:0] sat_load(logic [LOAD_W-1:0] a, logic [LOAD_W-1:0] b);
    logic [LOAD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LOAD_W] ? {LOAD_W{1'b1}} : s[LOAD_W-1:0];
  endfunction

  function automatic bit over_period(int i);
    return run_load[i] > per_w(i);
  endfunction

  function automatic void count_outcome(int k);
    if (outcome[k] != 16'hFFFF) outcome[k] = outcome[k] + 1'b1;
  endfunction

  // Deadline-ordered insert; returns 0 when any touched entry is overloaded.
  function automatic bit edf_insert(int id);
    bit ok;
    int pos;
    int e;
    ok = 1;
    pos = edf_len;
    if (edf_len >= NTASK) return 1;
    while (pos > 0 && due_at[id] < due_at[edf_order[pos-1]]) begin
      e = edf_order[pos-1];
      run_load[e] = sat_load(run_load[e], cost_w(id));
      if (over_period(e)) ok = 0;
      pos--;
    end
    run_load[id] = sat_load(cost_w(id), pos > 0 ? run_load[edf_order[pos-1]] : '0);
    for (int k = edf_len; k > pos; k--) edf_order[k] = edf_order[k-1];
    edf_order[pos] = TASK_W'(id);
    edf_len++;
    return ok && !over_period(id);
  endfunction

  function automatic bit edf_remove_at(int pos);
    bit ok;
    logic [LOAD_W-1:0] c;
    int e;
    ok = 1;
    if (pos >= edf_len) return 1;
    c = cost_w(edf_order[pos]);
    for (int k = pos + 1; k < edf_len; k++) begin
      e = edf_order[k];
      run_load[e] = (run_load[e] > c) ? run_load[e] - c : '0;
      if (over_period(e)) ok = 0;
      edf_order[k-1] = edf_order[k];
    end
    edf_len--;
    return ok;
  endfunction

  function automatic void edf_remove_task(int id);
    for (int k = 0; k < edf_len; k++) begin
      if (edf_order[k] == id) begin
        void'(edf_remove_at(k));
        return;
      end
    end
  endfunction

  // Bring back the rejected task with the latest deadline, high first.
  function automatic void readmit_one();
    int hi;
    int lo;
    int pick;
    hi = -1;
    lo = -1;
    for (int i = 0; i < NTASK; i++) begin
      if (task_state[i] != PH_REJECT) continue;
      if (task_setup[i][32]) begin
        if (hi < 0 || due_at[i] > due_at[hi]) hi = i;
      end else begin
        if (lo < 0 || due_at[i] > due_at[lo]) lo = i;
      end
    end
    pick = hi >= 0 ? hi : lo;
    if (pick < 0) return;
    if (edf_insert(pick)) task_state[pick] = PH_READY;
    else edf_remove_task(pick);
  endfunction

  function automatic void shed_overload();
    int lastlow;
    int first;
    int victim;
    forever begin
      lastlow = -1;
      first = -1;
      for (int k = 0; k < edf_len; k++) begin
        if (over_period(edf_order[k])) begin
          first = k;
          break;
        end
        if (!task_setup[edf_order[k]][32]) lastlow = k;
      end
      if (first < 0) return;
      if (!task_setup[edf_order[first]][32] || lastlow < 0) victim = first;
      else victim = lastlow;
      task_state[edf_order[victim]] = PH_REJECT;
      void'(edf_remove_at(victim));
    end
  endfunction

  function automatic result_t schedule_tick(bit job_done);
    result_t r;
    int h;
    if (job_done && edf_len > 0) begin
      h = edf_order[0];
      count_outcome(task_setup[h][32] ? CNT_SUCC_HIGH : CNT_SUCC_LOW);
      task_state[h] = PH_IDLE;
      wake_at[h] = time_plus(wake_at[h], task_setup[h][15:0]);
      if (edf_remove_at(0)) readmit_one();
    end
    for (int i = 0; i < NTASK; i++) begin
      if (task_state[i] != PH_IDLE && sched_now > due_at[i]) begin
        if (task_state[i] == PH_READY) edf_remove_task(i);
        task_state[i] = PH_IDLE;
        wake_at[i] = time_plus(wake_at[i], task_setup[i][15:0]);
        count_outcome(task_setup[i][32] ? CNT_FAIL_HIGH : CNT_FAIL_LOW);
      end
    end
    for (int i = 0; i < NTASK; i++) begin
      if (task_setup[i][33] && task_state[i] == PH_IDLE && sched_now >= wake_at[i]) begin
        task_state[i] = PH_READY;
        due_at[i] = time_plus(wake_at[i], task_setup[i][15:0]);
        void'(edf_insert(i));
        shed_overload();
      end
    end
    if (sched_now != 32'hFFFF_FFFF) sched_now = sched_now + 1'b1;
    r.running_valid  = edf_len > 0;
    r.running_task   = edf_len > 0 ? edf_order[0] : '0;
    r.succeeded_high = outcome[CNT_SUCC_HIGH];
    r.succeeded_low  = outcome[CNT_SUCC_LOW];
    r.failed_high    = outcome[CNT_FAIL_HIGH];
    r.failed_low     = outcome[CNT_FAIL_LOW];
    return r;
  endfunction

  // Tick driver: once the previous beat went through, a new one is loaded from the queue, at random unless steady.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) sched_expect_q.push_back(schedule_tick(in_tdata[0]));
      if (tick_done_q.size() > 0 && (steady || $urandom_range(0, 99) >= 24)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {7'd0, tick_done_q.pop_front()};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    result_t exp_r;
    cycle_count <= cycle_count + 1;
    out_tready  <= rst_n && (steady || $urandom_range(0, 99) >= 24);
    if (rst_n && out_tvalid && out_tready) begin
      if (sched_expect_q.size() == 0) begin
        fail_count++;
        $error("unexpected result beat");
      end else begin
        exp_r = sched_expect_q.pop_front();
        if (out_tuser[0] !== exp_r.running_valid) begin
          fail_count++;
          $error("running_valid exp %0d got %0d", exp_r.running_valid, out_tuser[0]);
        end
        if (out_tdata[2:0] !== exp_r.running_task) begin
          fail_count++;
          $error("running_task exp %0d got %0d", exp_r.running_task, out_tdata[2:0]);
        end
        if (out_tdata[18:3] !== exp_r.succeeded_high) begin
          fail_count++;
          $error("succeeded_high exp %0d got %0d", exp_r.succeeded_high, out_tdata[18:3]);
        end
        if (out_tdata[34:19] !== exp_r.succeeded_low) begin
          fail_count++;
          $error("succeeded_low exp %0d got %0d", exp_r.succeeded_low, out_tdata[34:19]);
        end
        if (out_tdata[50:35] !== exp_r.failed_high) begin
          fail_count++;
          $error("failed_high exp %0d got %0d", exp_r.failed_high, out_tdata[50:35]);
        end
        if (out_tdata[66:51] !== exp_r.failed_low) begin
          fail_count++;
          $error("failed_low exp %0d got %0d", exp_r.failed_low, out_tdata[66:51]);
        end
      end
    end
    if (cycle_count > TICK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_setup(int idx, logic [63:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= ADDR_W'(idx * 8);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    task_setup[idx] = value[SETUP_W-1:0];
  endtask

  // Mostly short periods so jobs release often; now and then an extreme.
  function automatic logic [63:0] random_setup();
    logic [15:0] per;
    logic [15:0] cost;
    logic [29:0] junk;
    junk = $urandom;
    case ($urandom_range(0, 19))
      0: return 64'd0;
      1: return {junk, 34'h3_FFFF_FFFF};
      2: return {junk, 1'b1, 1'($urandom), 16'($urandom_range(1, 9)), 16'd0};
      3: return {junk, 1'b1, 1'($urandom), 16'($urandom), 16'hFFFF};
      default: begin
        per  = 16'($urandom_range(2, 40));
        cost = 16'($urandom_range(0, per / 2 + 1));
        return {junk, 1'($urandom_range(0, 99) < 85), 1'($urandom), cost, per};
      end
    endcase
  endfunction

  // Queue up a run of ticks, then wait for every result and let the block settle.
  task automatic run_ticks(int count, int done_pct);
    for (int n = 0; n < count; n++) tick_done_q.push_back($urandom_range(0, 99) < done_pct);
    do @(posedge clk);
    while (tick_done_q.size() > 0 || in_tvalid || sched_expect_q.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    fail_count  = 0;
    cycle_count = 0;
    steady      = 1'b0;
    for (int i = 0; i < NTASK; i++) begin
      task_setup[i] = '0;
      task_state[i] = PH_IDLE;
      wake_at[i]    = '0;
      due_at[i]     = '0;
      run_load[i]   = '0;
      edf_order[i]  = '0;
    end
    for (int k = 0; k < NUM_CNT; k++) outcome[k] = '0;
    edf_len   = 0;
    sched_now = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed start: a high task, a zero-period task, a maximal task that
    // forces eviction, a pair sharing a deadline, and an absent task.
    write_setup(0, {30'd0, 1'b1, 1'b1, 16'd3, 16'd10});
    write_setup(1, {30'd0, 1'b1, 1'b0, 16'd5, 16'd0});
    write_setup(2, {30'd0, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF});
    write_setup(3, {30'd0, 1'b0, 1'b1, 16'd1, 16'd4});
    write_setup(4, {30'd0, 1'b1, 1'b0, 16'd2, 16'd6});
    write_setup(5, {30'd0, 1'b1, 1'b1, 16'd4, 16'd6});
    write_setup(6, {30'd0, 1'b1, 1'b0, 16'd0, 16'd5});
    write_setup(7, {30'h3FFF_FFFF, 1'b1, 1'b1, 16'd8, 16'd9});
    run_ticks(14, 40);
    // Clear task 0's present bit and raise task 5's cost while they may be queued.
    write_setup(0, {30'd0, 1'b0, 1'b1, 16'd3, 16'd10});
    write_setup(5, {30'd0, 1'b1, 1'b1, 16'd9, 16'd6});
    run_ticks(11, 60);

    for (int ph = 0; ph < 6; ph++) begin
      steady = (ph == 3);
      for (int i = 0; i < NTASK; i++) begin
        if (ph == 5) write_setup(i, {30'h3FFF_FFFF, 34'h3_FFFF_FFFF});
        else write_setup(i, random_setup());
      end
      run_ticks(ph == 5 ? 25 : 140, $urandom_range(10, 70));
    end
    steady = 1'b0;

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
